/* rtl/tslc_pkg.sv */
// Shared constants, codes and types of the tensor store layout converter.
`timescale 1ns / 1ps

package tslc_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_DIM      = 64;

    localparam int ADDR_W     = $clog2(MAX_ELEMENTS);
    localparam int SIZE_W     = ADDR_W + 1;
    localparam int PROD_W     = 4 * $clog2(MAX_DIM) + 1;
    localparam int DATA_W     = 32;
    localparam int CMD_W      = 2;
    localparam int IDX_W      = 6;
    localparam int DIM_W      = 7;
    localparam int RANK_W     = 3;
    localparam int STEP_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_N = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_W = 3'd4;

    localparam logic [RANK_W-1:0] RANK_FULL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHAPE,
        S_EXEC,
        S_WALK,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic shape_step;
        logic exec;
        logic walk_step;
        logic flip;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_shape;
        logic shape_last;
        logic bad;
        logic conv;
        logic size_zero;
        logic walk_last;
        logic nhwc;
    } t_dp_stat;

endpackage

/* rtl/tslc_in_if.sv */
// Command channel: valid/ready handshake with the command payload.
`timescale 1ns / 1ps

interface tslc_in_if;
    import tslc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [IDX_W-1:0]    index_0;
    logic [IDX_W-1:0]    index_1;
    logic [IDX_W-1:0]    index_2;
    logic [IDX_W-1:0]    index_3;
    logic [DATA_W-1:0]   write_value;

    modport source (
        output valid, command, index_0, index_1, index_2, index_3, write_value,
        input  ready
    );
    modport sink (
        input  valid, command, index_0, index_1, index_2, index_3, write_value,
        output ready
    );
endinterface

/* rtl/tslc_out_if.sv */
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface tslc_out_if;
    import tslc_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_value;
    logic              error;
    logic              layout_is_nhwc;

    modport source (
        output valid, read_value, error, layout_is_nhwc,
        input  ready
    );
    modport sink (
        input  valid, read_value, error, layout_is_nhwc,
        output ready
    );
endinterface

/* rtl/tslc_dp.sv */
// Datapath: configuration, shape and address unit, two element banks and the transpose walk.
`timescale 1ns / 1ps

module tslc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tslc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tslc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [tslc_pkg::CMD_W-1:0]         i_command,
    input  logic [tslc_pkg::IDX_W-1:0]         i_index_0,
    input  logic [tslc_pkg::IDX_W-1:0]         i_index_1,
    input  logic [tslc_pkg::IDX_W-1:0]         i_index_2,
    input  logic [tslc_pkg::IDX_W-1:0]         i_index_3,
    input  logic [tslc_pkg::DATA_W-1:0]        i_write_value,
    input  tslc_pkg::t_dp_cmd                  i_cmd,
    output tslc_pkg::t_dp_stat                 o_stat,
    output logic [tslc_pkg::DATA_W-1:0]        o_read_value,
    output logic                               o_error,
    output logic                               o_layout_is_nhwc
);
    import tslc_pkg::*;

    // Configuration and layout state.
    logic [RANK_W-1:0] r_rank;
    logic [DIM_W-1:0]  r_dim_n, r_dim_c, r_dim_h, r_dim_w;
    logic              r_nhwc;
    logic              r_active;

    // Latched command.
    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_idx [4];
    logic [DATA_W-1:0] r_wdata;
    logic              r_conv;

    // Shape and address unit.
    logic [STEP_W-1:0] r_step;
    logic              r_err;
    logic [PROD_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_hw_sz;
    logic [SIZE_W-1:0] r_chw_sz;
    logic              r_bad;

    // Transpose walk.
    logic [DIM_W-1:0]  r_c;
    logic [ADDR_W-1:0] r_hw;
    logic [ADDR_W-1:0] r_nbase;
    logic [ADDR_W-1:0] r_s;
    logic [ADDR_W-1:0] r_t;
    logic              r_wr_en;
    logic [ADDR_W-1:0] r_wr_addr;

    // Banks.
    logic [DATA_W-1:0] mem_a [MAX_ELEMENTS];
    logic [DATA_W-1:0] mem_b [MAX_ELEMENTS];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Result register.
    logic [DATA_W-1:0] r_read_value;
    logic              r_error;
    logic              r_layout;

    logic              w_rank_ok;
    logic              w_in_setget;
    logic              w_in_conv_ok;
    logic [DIM_W-1:0]  w_dim;
    logic [IDX_W-1:0]  w_idx;
    logic              w_step_err;
    logic [PROD_W-1:0] w_size_nx;
    logic [ADDR_W-1:0] w_addr_nx;
    logic              w_bad;
    logic              w_set_we;
    logic              w_get_re;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [DATA_W-1:0] w_wr_data;
    logic [DATA_W-1:0] w_src_rdata;
    logic              w_a_we, w_b_we;
    logic              w_c_wrap;
    logic              w_hw_wrap;

    assign w_rank_ok    = (r_rank != '0) && (r_rank <= RANK_FULL);
    assign w_in_setget  = (i_command == CMD_SET) || (i_command == CMD_GET);
    assign w_in_conv_ok = (i_command == CMD_CONVERT) && !r_nhwc && (r_rank == RANK_FULL);

    // A convert multiplies w, h, c, n in that order so that h*w and c*h*w fall out on the way.
    always_comb begin
        if (r_conv) begin
            unique case (r_step)
                2'd0:    w_dim = r_dim_w;
                2'd1:    w_dim = r_dim_h;
                2'd2:    w_dim = r_dim_c;
                default: w_dim = r_dim_n;
            endcase
        end else begin
            unique case (r_step)
                2'd0:    w_dim = r_dim_n;
                2'd1:    w_dim = r_nhwc ? r_dim_h : r_dim_c;
                2'd2:    w_dim = r_nhwc ? r_dim_w : r_dim_h;
                default: w_dim = r_nhwc ? r_dim_c : r_dim_w;
            endcase
        end
    end

    assign w_idx      = r_idx[r_step];
    assign w_step_err = (w_dim > DIM_W'(MAX_DIM)) || (!r_conv && ({1'b0, w_idx} >= w_dim));
    assign w_size_nx  = r_size * PROD_W'(w_dim);
    assign w_addr_nx  = r_addr * ADDR_W'(w_dim) + ADDR_W'(w_idx);
    assign w_bad      = r_err || (r_size > PROD_W'(MAX_ELEMENTS));

    assign w_set_we = i_cmd.exec && (r_cmd == CMD_SET) && !w_bad;
    assign w_get_re = i_cmd.exec && (r_cmd == CMD_GET) && !w_bad;

    // Only the active bank is ever read; a set writes it and the walk writes the other one.
    assign w_rd_en     = w_get_re || i_cmd.walk_step;
    assign w_rd_addr   = i_cmd.walk_step ? r_s : r_addr;
    assign w_src_rdata = r_active ? r_rdata_b : r_rdata_a;
    assign w_wr_addr   = w_set_we ? r_addr : r_wr_addr;
    assign w_wr_data   = w_set_we ? r_wdata : w_src_rdata;
    assign w_a_we      = (w_set_we && !r_active) || (r_wr_en && r_active);
    assign w_b_we      = (w_set_we && r_active) || (r_wr_en && !r_active);

    assign w_c_wrap  = (r_c == r_dim_c - DIM_W'(1));
    assign w_hw_wrap = ({1'b0, r_hw} == r_hw_sz - SIZE_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            mem_a[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en && !r_active) begin
            r_rdata_a <= mem_a[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_we) begin
            mem_b[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en && r_active) begin
            r_rdata_b <= mem_b[w_rd_addr];
        end
    end

    // Control state: configuration, layout and bank selection.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= RANK_FULL;
            r_dim_n  <= DIM_W'(1);
            r_dim_c  <= DIM_W'(1);
            r_dim_h  <= DIM_W'(1);
            r_dim_w  <= DIM_W'(1);
            r_nhwc   <= 1'b0;
            r_active <= 1'b0;
            r_wr_en  <= 1'b0;
        end else begin
            r_wr_en <= i_cmd.walk_step;
            if (i_cmd.flip) begin
                r_active <= ~r_active;
                r_nhwc   <= 1'b1;
            end
            // A write to any of the five configuration registers starts a new shape, so the layout falls back to NCHW.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RANK: begin
                        r_rank <= i_cfg_wdata[RANK_W-1:0];
                        r_nhwc <= 1'b0;
                    end
                    CFG_DIM_N: begin
                        r_dim_n <= i_cfg_wdata;
                        r_nhwc  <= 1'b0;
                    end
                    CFG_DIM_C: begin
                        r_dim_c <= i_cfg_wdata;
                        r_nhwc  <= 1'b0;
                    end
                    CFG_DIM_H: begin
                        r_dim_h <= i_cfg_wdata;
                        r_nhwc  <= 1'b0;
                    end
                    CFG_DIM_W: begin
                        r_dim_w <= i_cfg_wdata;
                        r_nhwc  <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cmd    <= i_command;
            r_idx[0] <= i_index_0;
            r_idx[1] <= i_index_1;
            r_idx[2] <= i_index_2;
            r_idx[3] <= i_index_3;
            r_wdata  <= i_write_value;
            r_conv   <= w_in_conv_ok;
            r_step   <= '0;
            r_err    <= w_in_setget && !w_rank_ok;
            r_size   <= PROD_W'(1);
            r_addr   <= '0;
        end
        if (i_cmd.shape_step) begin
            r_step <= r_step + STEP_W'(1);
            r_err  <= r_err || w_step_err;
            r_size <= w_size_nx;
            r_addr <= w_addr_nx;
            if (r_step == 2'd1) begin
                r_hw_sz <= SIZE_W'(w_size_nx);
            end
            if (r_step == 2'd2) begin
                r_chw_sz <= SIZE_W'(w_size_nx);
            end
        end
        if (i_cmd.exec) begin
            r_bad   <= w_bad;
            r_c     <= '0;
            r_hw    <= '0;
            r_nbase <= '0;
            r_s     <= '0;
            r_t     <= '0;
        end
        // Source offset steps by h*w along c, by one along h and w, and jumps a block along n.
        if (i_cmd.walk_step) begin
            r_wr_addr <= r_t;
            r_t       <= r_t + ADDR_W'(1);
            if (w_c_wrap) begin
                r_c <= '0;
                if (w_hw_wrap) begin
                    r_hw    <= '0;
                    r_nbase <= r_nbase + r_chw_sz[ADDR_W-1:0];
                    r_s     <= r_nbase + r_chw_sz[ADDR_W-1:0];
                end else begin
                    r_hw <= r_hw + ADDR_W'(1);
                    r_s  <= r_nbase + r_hw + ADDR_W'(1);
                end
            end else begin
                r_c <= r_c + DIM_W'(1);
                r_s <= r_s + r_hw_sz[ADDR_W-1:0];
            end
        end
        if (i_cmd.load) begin
            r_read_value <= ((r_cmd == CMD_GET) && !r_bad) ? w_src_rdata : '0;
            r_error      <= r_bad;
            r_layout     <= r_nhwc;
        end
    end

    assign o_stat.need_shape = (w_in_setget && w_rank_ok) || w_in_conv_ok;
    assign o_stat.shape_last = (RANK_W'(r_step) + RANK_W'(1)) == r_rank;
    assign o_stat.bad        = w_bad;
    assign o_stat.conv       = r_conv;
    assign o_stat.size_zero  = (r_size == '0);
    assign o_stat.walk_last  = ({1'b0, r_t} == SIZE_W'(r_size) - SIZE_W'(1));
    assign o_stat.nhwc       = r_nhwc;

    assign o_read_value     = r_read_value;
    assign o_error          = r_error;
    assign o_layout_is_nhwc = r_layout;

endmodule

/* rtl/tslc_ctrl.sv */
// Controller: sequences shape check, bank access and transpose walk, and owns both handshakes.
`timescale 1ns / 1ps

module tslc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tslc_pkg::t_dp_stat i_stat,
    output tslc_pkg::t_dp_cmd  o_cmd
);
    import tslc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_stat.need_shape ? S_SHAPE : S_EXEC;
                end
            end
            S_SHAPE: begin
                o_cmd.shape_step = 1'b1;
                if (i_stat.shape_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.conv && !i_stat.bad) begin
                    n_state = i_stat.size_zero ? S_DRAIN : S_WALK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last copied word is written while the banks swap roles.
                o_cmd.flip = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* rtl/tensor_store_layout_converter.sv */
// Top level of the tensor store layout converter: controller, datapath and channel wiring.
//
//  channel   dir  handshake        beat contents
//  i_req     in   valid / ready    command, index_0..3, write_value
//  o_rsp     out  valid / ready    read_value, error, layout_is_nhwc
//  i_cfg_*   in   write enable     register index, 7-bit data (rank, dim_n, dim_c, dim_h, dim_w)
//
// A set or get of rank 1 to 4 passes through acceptance, one multiply-add step per used
// dimension, one bank access and the loading of the result. An applicable convert runs the
// shape steps, walks one element per cycle, drains and swaps the banks; a shape that is too big
// skips the walk. Every other command goes straight to the execute and load steps. One command is in flight at a time.
// Reset is synchronous; banks hold no reset value and need no clearing pass.
// A result waiting on o_rsp does not block the next command, only the loading of its result.
`timescale 1ns / 1ps

module tensor_store_layout_converter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tslc_in_if.sink                         i_req,
    tslc_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [tslc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tslc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import tslc_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tslc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tslc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_command        (i_req.command),
        .i_index_0        (i_req.index_0),
        .i_index_1        (i_req.index_1),
        .i_index_2        (i_req.index_2),
        .i_index_3        (i_req.index_3),
        .i_write_value    (i_req.write_value),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_read_value     (o_rsp.read_value),
        .o_error          (o_rsp.error),
        .o_layout_is_nhwc (o_rsp.layout_is_nhwc)
    );

    // A result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_rsp.valid || o_rsp.ready))
        else $error("result loaded over an untaken beat");

    // No command is taken while the transpose walk owns the banks.
    a_walk_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.walk_step |-> !i_req.ready)
        else $error("command accepted during transpose walk");

    // A write to any of the five configuration registers returns the layout to NCHW.
    a_cfg_resets_layout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx <= CFG_DIM_W)) |=> !w_stat.nhwc)
        else $error("layout not NCHW after register write");

endmodule
